// File: hdl/i2cm_pkg.sv
package i2cm_pkg;

  localparam logic [6:0] ADDR_RESET = 7'd77;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_ADDR     = 4'd2,
    PH_ADDR_ACK = 4'd3,
    PH_WDATA    = 4'd4,
    PH_WDATA_AK = 4'd5,
    PH_RDATA    = 4'd6,
    PH_RACK     = 4'd7,
    PH_STOP     = 4'd8
  } phase_t;

  localparam logic [1:0] TICK_FIRST  = 2'd0;
  localparam logic [1:0] TICK_SECOND = 2'd1;
  localparam logic [1:0] TICK_THIRD  = 2'd2;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// File: hdl/i2c_master_single_transaction_top.sv
// i2c master, one transaction at a time, 7-bit addressing, driven by ticks
// tick channel (tick_valid/tick_ready): one word per half-period of scl,
//   carrying the sampled sda level and, while idle, a write or read request
// result channel (res_valid/res_ready): one word per accepted tick with the
//   scl/sda drive levels, a received byte strobe, busy, done and success
// apb port: device_address at byte address 0, 7 bits, reset 77
// the result of a tick is registered and is on the result port in the cycle
//   after the tick is accepted
// throughput: one tick per cycle while the receiver takes results; the
//   sequencer state and the result register are updated in the same cycle that a tick is taken
// a tick is taken whenever the result register is empty or being read, so
//   a stalled receiver holds the current result and stalls the tick channel
//   one word deep
// reset: bus idle (sequencer in idle, result register empty), address 77
// a transaction is start (2 ticks), address byte and ack (18 ticks), the
//   data phase (18 ticks per byte), then stop (3 ticks, last is done)
module i2c_master_single_transaction_top
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  tick_valid,
  output logic                  tick_ready,
  input  logic [1:0]            req_type,
  input  logic [7:0]            write_data,
  input  logic [7:0]            read_count,
  input  logic                  sda_sample,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  scl_level,
  output logic                  sda_release,
  output logic                  byte_valid,
  output logic [7:0]            read_data,
  output logic                  busy_res,
  output logic                  done_res,
  output logic                  success
);

  logic [6:0] device_address;
  phase_t     phase, phase_next;
  logic [1:0] tick_in_bit, tick_in_bit_next;
  logic [3:0] bit_count, bit_count_next;
  logic [3:0] bit_inc;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic       is_read, is_read_next;
  logic       addr_acked, addr_acked_next;
  logic [7:0] held_write_data, held_write_data_next;

  logic       scl_next, sda_next, bv_next, busy_next, done_next, succ_next;
  logic [7:0] rdata_next;
  logic       take;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(APB_DATA_W-7){1'b0}}, device_address}
                                     : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      device_address <= pwdata[6:0];
    end
  end

  // handshake
  assign tick_ready = !res_valid || res_ready;
  assign take       = tick_valid && tick_ready;
  assign bit_inc    = bit_count + 4'd1;

  always_comb begin
    phase_next           = phase;
    tick_in_bit_next     = tick_in_bit;
    bit_count_next       = bit_count;
    shift_byte_next      = shift_byte;
    bytes_left_next      = bytes_left;
    is_read_next         = is_read;
    addr_acked_next      = addr_acked;
    held_write_data_next = held_write_data;
    scl_next   = 1'b1;
    sda_next   = 1'b1;
    bv_next    = 1'b0;
    rdata_next = 8'd0;
    busy_next  = 1'b1;
    done_next  = 1'b0;
    succ_next  = 1'b0;

    if (phase == PH_IDLE && (req_type == REQ_WRITE || req_type == REQ_READ)) begin
      is_read_next         = (req_type == REQ_READ);
      held_write_data_next = write_data;
      bytes_left_next      = read_count;
      addr_acked_next      = 1'b0;
      shift_byte_next      = {device_address, req_type == REQ_READ};
      bit_count_next       = 4'd0;
      tick_in_bit_next     = TICK_FIRST;
      phase_next           = PH_START;
    end

    unique case (phase_next)
      PH_IDLE: begin
        busy_next = 1'b0;
      end
      PH_START: begin
        if (tick_in_bit_next == TICK_FIRST) begin
          tick_in_bit_next = TICK_SECOND;
        end else begin
          sda_next         = 1'b0;
          tick_in_bit_next = TICK_FIRST;
          bit_count_next   = 4'd0;
          phase_next       = PH_ADDR;
        end
      end
      PH_ADDR, PH_WDATA: begin
        sda_next = shift_byte[7];
        if (tick_in_bit == TICK_FIRST) begin
          scl_next         = 1'b0;
          tick_in_bit_next = TICK_SECOND;
        end else begin
          shift_byte_next  = {shift_byte[6:0], 1'b0};
          bit_count_next   = bit_inc;
          tick_in_bit_next = TICK_FIRST;
          if (bit_inc >= BITS_PER_BYTE) begin
            bit_count_next = 4'd0;
            phase_next     = (phase == PH_ADDR) ? PH_ADDR_ACK : PH_WDATA_AK;
          end
        end
      end
      PH_ADDR_ACK, PH_WDATA_AK: begin
        if (tick_in_bit == TICK_FIRST) begin
          scl_next         = 1'b0;
          tick_in_bit_next = TICK_SECOND;
        end else begin
          tick_in_bit_next = TICK_FIRST;
          if (phase == PH_WDATA_AK) begin
            phase_next = PH_STOP;
          end else begin
            addr_acked_next = !sda_sample;
            if (sda_sample) begin
              phase_next = PH_STOP;
            end else if (is_read) begin
              shift_byte_next = 8'd0;
              phase_next      = (bytes_left == 8'd0) ? PH_STOP : PH_RDATA;
            end else begin
              shift_byte_next = held_write_data;
              phase_next      = PH_WDATA;
            end
          end
        end
      end
      PH_RDATA: begin
        if (tick_in_bit == TICK_FIRST) begin
          scl_next         = 1'b0;
          tick_in_bit_next = TICK_SECOND;
        end else begin
          shift_byte_next  = {shift_byte[6:0], sda_sample};
          bit_count_next   = bit_inc;
          tick_in_bit_next = TICK_FIRST;
          if (bit_inc >= BITS_PER_BYTE) begin
            bit_count_next  = 4'd0;
            bytes_left_next = bytes_left - 8'd1;
            phase_next      = PH_RACK;
          end
        end
      end
      PH_RACK: begin
        sda_next = (bytes_left == 8'd0);
        if (tick_in_bit == TICK_FIRST) begin
          scl_next         = 1'b0;
          tick_in_bit_next = TICK_SECOND;
        end else begin
          bv_next          = 1'b1;
          rdata_next       = shift_byte;
          shift_byte_next  = 8'd0;
          tick_in_bit_next = TICK_FIRST;
          phase_next       = (bytes_left == 8'd0) ? PH_STOP : PH_RDATA;
        end
      end
      PH_STOP: begin
        if (tick_in_bit == TICK_FIRST) begin
          scl_next         = 1'b0;
          sda_next         = 1'b0;
          tick_in_bit_next = TICK_SECOND;
        end else if (tick_in_bit == TICK_SECOND) begin
          sda_next         = 1'b0;
          tick_in_bit_next = TICK_THIRD;
        end else begin
          busy_next        = 1'b0;
          done_next        = 1'b1;
          succ_next        = addr_acked;
          tick_in_bit_next = TICK_FIRST;
          phase_next       = PH_IDLE;
        end
      end
      default: begin
        busy_next        = 1'b0;
        tick_in_bit_next = TICK_FIRST;
        bit_count_next   = 4'd0;
        phase_next       = PH_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_in_bit     <= TICK_FIRST;
      bit_count       <= 4'd0;
      shift_byte      <= 8'd0;
      bytes_left      <= 8'd0;
      is_read         <= 1'b0;
      addr_acked      <= 1'b0;
      held_write_data <= 8'd0;
    end else if (take) begin
      phase           <= phase_next;
      tick_in_bit     <= tick_in_bit_next;
      bit_count       <= bit_count_next;
      shift_byte      <= shift_byte_next;
      bytes_left      <= bytes_left_next;
      is_read         <= is_read_next;
      addr_acked      <= addr_acked_next;
      held_write_data <= held_write_data_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scl_level   <= scl_next;
      sda_release <= sda_next;
      byte_valid  <= bv_next;
      read_data   <= rdata_next;
      busy_res    <= busy_next;
      done_res    <= done_next;
      success     <= succ_next;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res && !byte_valid)
    else $error("done word still busy or carrying a byte");

  a_success_only_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && success |-> done_res)
    else $error("success without done");

  a_byte_in_transaction: assert property (@(posedge clk) disable iff (rst)
    res_valid && byte_valid |-> busy_res && scl_level)
    else $error("received byte outside a transaction or on scl low");

  a_idle_tick_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_in_bit == TICK_FIRST)
    else $error("idle with a half-finished bit");

  a_idle_bus_free: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_IDLE && phase_next == PH_IDLE |=> scl_level && sda_release)
    else $error("bus not released while idle");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
  import i2cm_pkg::*;
();

  localparam logic [APB_ADDR_W-1:0] REG_DEVICE_ADDRESS = '0;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_WAIT = 10;
  localparam int MAX_GAP = 20;
  localparam int PHASE_ITEMS = 150;
  localparam int IDLE_PCT[4] = '{0, 65, 0, 31};
  localparam int STALL_PCT[4] = '{0, 0, 65, 31};

  typedef struct packed {
    req_t       req;
    logic [7:0] wdata;
    logic [7:0] rcount;
    logic       sda;
  } tick_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       bv;
    logic [7:0] data;
    logic       busy;
    logic       done;
    logic       ok;
  } bus_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  tick_valid = 1'b0;
  logic                  tick_ready;
  logic [1:0]            req_type = REQ_TICK;
  logic [7:0]            write_data = '0;
  logic [7:0]            read_count = '0;
  logic                  sda_sample = 1'b1;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic                  scl_level;
  logic                  sda_release;
  logic                  byte_valid;
  logic [7:0]            read_data;
  logic                  busy_res;
  logic                  done_res;
  logic                  success;

  i2c_master_single_transaction_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bus sequencer mirror
  phase_t     ph = PH_IDLE;
  logic [1:0] tick_pos = TICK_FIRST;
  logic [3:0] nbits = '0;
  logic [7:0] shreg = '0;
  logic [7:0] remaining = '0;
  logic       rd_dir = 1'b0;
  logic       acked = 1'b0;
  logic [7:0] wbyte = '0;
  logic [6:0] dev_addr = ADDR_RESET;

  bus_word_t expected_words[$];
  int idle_pct = 0;
  int stall_pct = 0;
  bit drain_pending = 1'b0;
  int items_sent = 0;
  int mismatches = 0;
  int words_checked = 0;
  int bytes_received = 0;
  int transfers_done = 0;
  int transfers_nacked = 0;
  int idle_cycles = 0;

  function automatic bus_word_t bus_step(tick_word_t t);
    bus_word_t w;
    w = '0;
    w.scl = 1'b1;
    w.sda = 1'b1;
    w.busy = 1'b1;
    if (ph == PH_IDLE && (t.req == REQ_WRITE || t.req == REQ_READ)) begin
      rd_dir = (t.req == REQ_READ);
      wbyte = t.wdata;
      remaining = t.rcount;
      acked = 1'b0;
      shreg = {dev_addr, rd_dir};
      nbits = '0;
      tick_pos = TICK_FIRST;
      ph = PH_START;
    end
    case (ph)
      PH_IDLE: w.busy = 1'b0;
      PH_START: begin
        if (tick_pos == TICK_FIRST) begin
          tick_pos = TICK_SECOND;
        end else begin
          w.sda = 1'b0;
          tick_pos = TICK_FIRST;
          nbits = '0;
          ph = PH_ADDR;
        end
      end
      PH_ADDR, PH_WDATA: begin
        w.sda = shreg[7];
        if (tick_pos == TICK_FIRST) begin
          w.scl = 1'b0;
          tick_pos = TICK_SECOND;
        end else begin
          shreg = shreg << 1;
          nbits = nbits + 4'd1;
          tick_pos = TICK_FIRST;
          if (nbits >= BITS_PER_BYTE) begin
            nbits = '0;
            ph = (ph == PH_ADDR) ? PH_ADDR_ACK : PH_WDATA_AK;
          end
        end
      end
      PH_ADDR_ACK, PH_WDATA_AK: begin
        if (tick_pos == TICK_FIRST) begin
          w.scl = 1'b0;
          tick_pos = TICK_SECOND;
        end else begin
          tick_pos = TICK_FIRST;
          if (ph == PH_WDATA_AK) begin
            ph = PH_STOP;
          end else begin
            acked = !t.sda;
            if (!acked) begin
              ph = PH_STOP;
            end else if (rd_dir) begin
              shreg = '0;
              ph = (remaining == 8'd0) ? PH_STOP : PH_RDATA;
            end else begin
              shreg = wbyte;
              ph = PH_WDATA;
            end
          end
        end
      end
      PH_RDATA: begin
        if (tick_pos == TICK_FIRST) begin
          w.scl = 1'b0;
          tick_pos = TICK_SECOND;
        end else begin
          shreg = {shreg[6:0], t.sda};
          nbits = nbits + 4'd1;
          tick_pos = TICK_FIRST;
          if (nbits >= BITS_PER_BYTE) begin
            nbits = '0;
            remaining = remaining - 8'd1;
            ph = PH_RACK;
          end
        end
      end
      PH_RACK: begin
        w.sda = (remaining == 8'd0);
        if (tick_pos == TICK_FIRST) begin
          w.scl = 1'b0;
          tick_pos = TICK_SECOND;
        end else begin
          w.bv = 1'b1;
          w.data = shreg;
          shreg = '0;
          tick_pos = TICK_FIRST;
          ph = (remaining == 8'd0) ? PH_STOP : PH_RDATA;
        end
      end
      PH_STOP: begin
        if (tick_pos == TICK_FIRST) begin
          w.scl = 1'b0;
          w.sda = 1'b0;
          tick_pos = TICK_SECOND;
        end else if (tick_pos == TICK_SECOND) begin
          w.sda = 1'b0;
          tick_pos = TICK_THIRD;
        end else begin
          w.busy = 1'b0;
          w.done = 1'b1;
          w.ok = acked;
          tick_pos = TICK_FIRST;
          ph = PH_IDLE;
        end
      end
      default: begin
        w.busy = 1'b0;
        tick_pos = TICK_FIRST;
        nbits = '0;
        ph = PH_IDLE;
      end
    endcase
    return w;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bus_word_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, expected nothing, got scl %0b sda %0b",
                 $time, scl_level, sda_release);
      end else begin
        want = expected_words.pop_front();
        check_field("scl_level", 8'(want.scl), 8'(scl_level));
        check_field("sda_release", 8'(want.sda), 8'(sda_release));
        check_field("byte_valid", 8'(want.bv), 8'(byte_valid));
        check_field("read_data", want.data, read_data);
        check_field("busy_res", 8'(want.busy), 8'(busy_res));
        check_field("done_res", 8'(want.done), 8'(done_res));
        check_field("success", 8'(want.ok), 8'(success));
        words_checked++;
        if (want.bv) bytes_received++;
        if (want.done) begin
          transfers_done++;
          if (!want.ok) transfers_nacked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (tick_valid && tick_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(tick_word_t t);
    int gap;
    bit drain;
    gap = 0;
    while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    drain = drain_pending && (ph != PH_IDLE);
    if (drain && gap == 0) gap = 1;
    if (gap != 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        drain_pending = 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
      end
    end
    tick_valid <= 1'b1;
    req_type <= t.req;
    write_data <= t.wdata;
    read_count <= t.rcount;
    sda_sample <= t.sda;
    do @(posedge clk); while (!tick_ready);
    expected_words.push_back(bus_step(t));
    items_sent++;
  endtask

  // one request word, then ticks (random request codes at noise_pct) until the stop condition completes
  task automatic run_transaction(req_t kind, logic [7:0] wd, logic [7:0] rc,
                                 int ack_pct, int noise_pct);
    tick_word_t t;
    t.req = kind;
    t.wdata = wd;
    t.rcount = rc;
    t.sda = 1'($urandom_range(1));
    send_tick(t);
    while (ph != PH_IDLE) begin
      t.req = ($urandom_range(99) < noise_pct) ? req_t'($urandom_range(3)) : REQ_TICK;
      if (noise_pct == 100 && ph == PH_STOP && tick_pos == TICK_THIRD) t.req = REQ_READ;
      t.wdata = 8'($urandom);
      t.rcount = 8'($urandom);
      if (ph == PH_ADDR_ACK && tick_pos == TICK_SECOND)
        t.sda = ($urandom_range(99) >= ack_pct);
      else
        t.sda = 1'($urandom_range(1));
      send_tick(t);
    end
  endtask

  task automatic wait_drained;
    tick_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_address_reg;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_DEVICE_ADDRESS;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("device_address", {1'b0, dev_addr}, {1'b0, prdata[6:0]});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_address(logic [6:0] a);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_DEVICE_ADDRESS;
    pwdata <= {{(APB_DATA_W-7){1'b0}}, a};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dev_addr = a;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    check_address_reg();
  endtask

  task automatic test_directed;
    run_transaction(REQ_TICK, 8'h00, 8'h00, 100, 0);
    run_transaction(REQ_NONE, 8'hFF, 8'hFF, 100, 0);
    run_transaction(REQ_WRITE, 8'hFF, 8'h00, 100, 0);
    // random request codes while busy, a read request on the done tick
    run_transaction(REQ_WRITE, 8'h00, 8'hFF, 100, 100);
    run_transaction(REQ_WRITE, 8'hA5, 8'h5A, 0, 0);
    run_transaction(REQ_READ, 8'h00, 8'h00, 100, 0);
    run_transaction(REQ_READ, 8'hFF, 8'h01, 100, 0);
    run_transaction(REQ_READ, 8'h00, 8'h02, 100, 0);
    run_transaction(REQ_READ, 8'h5A, 8'hFF, 0, 0);
  endtask

  task automatic test_address_extremes;
    set_address(7'h00);
    run_transaction(REQ_WRITE, 8'h3C, 8'h00, 100, 0);
    set_address(7'h7F);
    run_transaction(REQ_READ, 8'hC3, 8'h01, 100, 0);
    set_address(7'h55);
    run_transaction(REQ_WRITE, 8'h96, 8'h00, 100, 0);
    set_address(7'h2A);
    run_transaction(REQ_READ, 8'h69, 8'h01, 100, 0);
  endtask

  task automatic test_long_read;
    idle_pct = 31;
    stall_pct = 31;
    run_transaction(REQ_READ, 8'($urandom), 8'h20, 100, 0);
  endtask

  task automatic random_transaction;
    int pick;
    logic [7:0] rc;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4))
        run_transaction($urandom_range(1) ? REQ_NONE : REQ_TICK,
                        8'($urandom), 8'($urandom), 100, 0);
    end else if (pick < 50) begin
      run_transaction(REQ_WRITE, 8'($urandom), 8'($urandom), 85, 5);
    end else begin
      rc = ($urandom_range(9) == 0) ? 8'($urandom_range(20, 4)) : 8'($urandom_range(3));
      run_transaction(REQ_READ, 8'($urandom), rc, 85, 5);
    end
  endtask

  task automatic test_random_traffic;
    int target;
    for (int p = 0; p < 4; p++) begin
      set_address(7'($urandom_range(127)));
      idle_pct = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      drain_pending = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_transaction();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_address_reg();
    test_directed();
    test_address_extremes();
    test_long_read();
    test_random_traffic();
    tick_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    $display("ticks sent %0d, result words checked %0d, mismatches %0d",
             items_sent, words_checked, mismatches);
    $display("transactions finished %0d (%0d not acknowledged), bytes read %0d",
             transfers_done, transfers_nacked, bytes_received);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
